/* design/inp_pkg.sv */
// Shared types, constants and the character classifier for the integer numeral parser.
// No dependencies.
`default_nettype none

package inp_pkg;

  localparam int unsigned ValueWidth = 64;
  localparam int unsigned CharWidth  = 8;
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = 1;

  // Largest decimal accumulator that may still take one more digit.
  localparam logic [ValueWidth-1:0] DecLimitDiv10 = 64'd922337203685477580;
  localparam logic [3:0]            DecLimitLast  = 4'd7;

  localparam logic [CharWidth-1:0] ChNul   = 8'h00;
  localparam logic [CharWidth-1:0] ChSpace = 8'h20;
  localparam logic [CharWidth-1:0] ChTab   = 8'h09;
  localparam logic [CharWidth-1:0] ChCr    = 8'h0d;
  localparam logic [CharWidth-1:0] ChZero  = 8'h30;
  localparam logic [CharWidth-1:0] ChNine  = 8'h39;
  localparam logic [CharWidth-1:0] ChLowA  = 8'h61;
  localparam logic [CharWidth-1:0] ChLowF  = 8'h66;
  localparam logic [CharWidth-1:0] ChUpA   = 8'h41;
  localparam logic [CharWidth-1:0] ChUpF   = 8'h46;
  localparam logic [CharWidth-1:0] ChLowX  = 8'h78;
  localparam logic [CharWidth-1:0] ChUpX   = 8'h58;
  localparam logic [CharWidth-1:0] ChMinus = 8'h2d;
  localparam logic [CharWidth-1:0] ChPlus  = 8'h2b;

  // Classified character as it travels from front to back.
  typedef struct packed {
    logic       term;
    logic       ws;
    logic       dec;
    logic       hexd;
    logic       zero_ch;
    logic       xch;
    logic       minus;
    logic       plus;
    logic [3:0] hval;
  } inp_cls_t;

  typedef enum logic [6:0] {
    PH_LEAD  = 7'b0000001,
    PH_SIGN  = 7'b0000010,
    PH_ZERO  = 7'b0000100,
    PH_DEC   = 7'b0001000,
    PH_HEX   = 7'b0010000,
    PH_TRAIL = 7'b0100000,
    PH_FAIL  = 7'b1000000
  } inp_phase_t;

  function automatic inp_cls_t inp_classify(input logic [CharWidth-1:0] c);
    inp_cls_t   r;
    logic       is_dec;
    logic       is_lo;
    logic       is_up;
    logic [7:0] off;
    is_dec = (c >= ChZero) && (c <= ChNine);
    is_lo  = (c >= ChLowA) && (c <= ChLowF);
    is_up  = (c >= ChUpA) && (c <= ChUpF);
    r.term    = (c == ChNul);
    r.ws      = (c == ChSpace) || ((c >= ChTab) && (c <= ChCr));
    r.dec     = is_dec;
    r.hexd    = is_dec || is_lo || is_up;
    r.zero_ch = (c == ChZero);
    r.xch     = (c == ChLowX) || (c == ChUpX);
    r.minus   = (c == ChMinus);
    r.plus    = (c == ChPlus);
    if (is_lo) begin
      off = c - ChLowA + 8'd10;
    end else if (is_up) begin
      off = c - ChUpA + 8'd10;
    end else begin
      off = c - ChZero;
    end
    r.hval = off[3:0];
    return r;
  endfunction

endpackage

`default_nettype wire

/* design/inp_front.sv */
// Front end: input handshake and character classification.
// Depends on inp_pkg.
`default_nettype none

module inp_front (
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [inp_pkg::CharWidth-1:0] in_char_code,
  input  wire logic                       q_not_full,
  output logic                            q_push,
  output inp_pkg::inp_cls_t               q_push_data
);
  import inp_pkg::*;

  assign in_ready    = q_not_full;
  assign q_push      = in_valid && q_not_full;
  assign q_push_data = inp_classify(in_char_code);

endmodule

`default_nettype wire

/* design/inp_queue.sv */
// Two-entry queue of classified characters between front and back.
// Depends on inp_pkg.
`default_nettype none

module inp_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire inp_pkg::inp_cls_t  push_data,
  input  wire logic               pop,
  output inp_pkg::inp_cls_t       head,
  output logic                    not_empty,
  output logic                    not_full
);
  import inp_pkg::*;

  inp_cls_t               mem_r [QueueDepth];
  logic [QueuePtrW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QueuePtrW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QueuePtrW:0]     cnt_r, cnt_nxt;

  assign not_empty = (cnt_r != '0);
  assign not_full  = (cnt_r != (QueuePtrW+1)'(QueueDepth));
  assign head      = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QueuePtrW+1)'(push) - (QueuePtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

/* design/inp_back.sv */
// Back end: numeral parsing state machine, accumulator and result register.
// Depends on inp_pkg.
`default_nettype none

module inp_back (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire inp_pkg::inp_cls_t                 head,
  input  wire logic                              q_not_empty,
  output logic                                   q_pop,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_ok,
  output logic signed [inp_pkg::ValueWidth-1:0]  out_value
);
  import inp_pkg::*;

  inp_phase_t             phase_r, phase_nxt;
  logic                   neg_r, neg_nxt;
  logic [ValueWidth-1:0]  acc_r, acc_nxt;
  logic                   nodig_r, nodig_nxt;
  logic                   ovalid_r, ovalid_nxt;
  logic                   ook_r, ook_nxt;
  logic [ValueWidth-1:0]  oval_r, oval_nxt;

  logic                   out_free;
  logic [ValueWidth-1:0]  dec_sum;
  logic                   dec_ovf;
  logic                   good;

  assign out_free = !ovalid_r || out_ready;
  assign q_pop    = q_not_empty && (!head.term || out_free);

  // acc*10 + digit as two shifted copies plus the digit
  assign dec_sum = {acc_r[ValueWidth-4:0], 3'b000} + {acc_r[ValueWidth-2:0], 1'b0}
                 + {{(ValueWidth-4){1'b0}}, head.hval};
  assign dec_ovf = (acc_r >= DecLimitDiv10)
                && ((acc_r > DecLimitDiv10) || (head.hval > DecLimitLast + {3'b000, neg_r}));

  assign good = ((phase_r == PH_ZERO) || (phase_r == PH_DEC) || (phase_r == PH_HEX)
              || (phase_r == PH_TRAIL)) && !nodig_r;

  always_comb begin
    phase_nxt  = phase_r;
    neg_nxt    = neg_r;
    acc_nxt    = acc_r;
    nodig_nxt  = nodig_r;
    ovalid_nxt = ovalid_r && !out_ready;
    ook_nxt    = ook_r;
    oval_nxt   = oval_r;
    if (q_pop) begin
      if (head.term) begin
        ovalid_nxt = 1'b1;
        ook_nxt    = good;
        oval_nxt   = !good ? '0 : (neg_r ? ('0 - acc_r) : acc_r);
        phase_nxt  = PH_LEAD;
        neg_nxt    = 1'b0;
        acc_nxt    = '0;
        nodig_nxt  = 1'b1;
      end else begin
        unique case (phase_r)
          PH_LEAD, PH_SIGN: begin
            if (phase_r == PH_LEAD && head.ws) begin
              phase_nxt = PH_LEAD;
            end else if (phase_r == PH_LEAD && head.minus) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_SIGN;
            end else if (phase_r == PH_LEAD && head.plus) begin
              phase_nxt = PH_SIGN;
            end else if (head.zero_ch) begin
              nodig_nxt = 1'b0;
              phase_nxt = PH_ZERO;
            end else if (head.dec) begin
              acc_nxt   = dec_sum;
              nodig_nxt = 1'b0;
              phase_nxt = PH_DEC;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_ZERO: begin
            if (head.xch) begin
              nodig_nxt = 1'b1;
              phase_nxt = PH_HEX;
            end else if (head.dec) begin
              acc_nxt   = dec_sum;
              nodig_nxt = 1'b0;
              phase_nxt = PH_DEC;
            end else if (head.ws) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_DEC: begin
            if (head.dec) begin
              if (dec_ovf) begin
                phase_nxt = PH_FAIL;
              end else begin
                acc_nxt   = dec_sum;
                nodig_nxt = 1'b0;
              end
            end else if (head.ws) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_HEX: begin
            if (head.hexd) begin
              acc_nxt   = {acc_r[ValueWidth-5:0], head.hval};
              nodig_nxt = 1'b0;
            end else if (head.ws) begin
              phase_nxt = PH_TRAIL;
            end else begin
              phase_nxt = PH_FAIL;
            end
          end
          PH_TRAIL: begin
            if (!head.ws) begin
              phase_nxt = PH_FAIL;
            end
          end
          default: begin
            phase_nxt = PH_FAIL;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_LEAD;
      neg_r    <= 1'b0;
      acc_r    <= '0;
      nodig_r  <= 1'b1;
      ovalid_r <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      neg_r    <= neg_nxt;
      acc_r    <= acc_nxt;
      nodig_r  <= nodig_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ook_r  <= ook_nxt;
    oval_r <= oval_nxt;
  end

  assign out_valid = ovalid_r;
  assign out_ok    = ook_r;
  assign out_value = oval_r;

endmodule

`default_nettype wire

/* design/integer_numeral_parser.sv */
// Top level of the integer numeral parser.
// Depends on inp_pkg, inp_front, inp_queue and inp_back.
//
// Usage:
//   in_*  : one character per word (in_char_code). A zero byte ends the string.
//           Leading blanks, an optional sign, then decimal digits or 0x/0X and
//           hex digits, then optional trailing blanks.
//   out_* : one word per string, sent only at the terminator: out_ok and the
//           signed 64-bit out_value (zero when out_ok is low).
// Throughput: one character per cycle while no terminator waits on a stalled
//   result; per character, one 64-bit multiply-by-ten add and compare.
// Output: an accepted terminator is queued; at the queue head, with the result
//   register free, the back end pops it and registers out_valid and the result.
// Stall: while a result waits on out_ready, the back end keeps working on
//   non-terminator characters; it holds only at the next terminator. The
//   two-word queue keeps in_ready high until it fills.
// Reset: rst_n (synchronous, low) empties the queue, drops out_valid and
//   returns the parser to the leading-blank phase with a cleared value.
`default_nettype none

module integer_numeral_parser (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_valid,
  output logic                                   in_ready,
  input  wire logic [inp_pkg::CharWidth-1:0]     in_char_code,
  output logic                                   out_valid,
  input  wire logic                              out_ready,
  output logic                                   out_ok,
  output logic signed [inp_pkg::ValueWidth-1:0]  out_value
);
  import inp_pkg::*;

  logic     q_push;
  inp_cls_t q_push_data;
  logic     q_pop;
  inp_cls_t q_head;
  logic     q_not_empty;
  logic     q_not_full;

  inp_front u_front (
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_char_code (in_char_code),
    .q_not_full   (q_not_full),
    .q_push       (q_push),
    .q_push_data  (q_push_data)
  );

  inp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .not_empty (q_not_empty),
    .not_full  (q_not_full)
  );

  inp_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .head        (q_head),
    .q_not_empty (q_not_empty),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_ok      (out_ok),
    .out_value   (out_value)
  );

endmodule

`default_nettype wire

/* design/inp_checker.sv */
// Port-level checks for the integer numeral parser, bound to the top level.
// Depends on inp_pkg.
`default_nettype none

module inp_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic                              out_ok,
  input wire logic signed [inp_pkg::ValueWidth-1:0] out_value
);
  import inp_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_ok) && $stable(out_value))
    else $error("result changed while stalled");

  // a failed string reports zero
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ok |-> out_value == '0)
    else $error("nonzero value with ok low");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    $past(!rst_n) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

bind integer_numeral_parser inp_checker u_inp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_ok    (out_ok),
  .out_value (out_value)
);

`default_nettype wire
